FILE: rtl/isp_pkg.sv
package isp_pkg;

	// Defaults for the top-level parameters.
	localparam int ENTRIES_DEF    = 1024;
	localparam int DEGREE_DEF     = 3;
	localparam int BLOCK_BITS_DEF = 6;
	localparam int PAGE_BITS_DEF  = 12;

	// Fixed field widths.
	localparam int ADDR_W = 64;
	localparam int CAP_W  = 9;
	localparam logic [CAP_W-1:0] CAP_RESET = 9'd32;

	// States of the tracker sequencer.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_TOUCH
	} trk_state_t;

endpackage

FILE: rtl/isp_queue.sv
module isp_queue import isp_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = slot_q[rd_ptr_q];

	// Two-slot storage; written only when there is room.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if ((push && !full) && !(pop && !empty)) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!(push && !full) && (pop && !empty)) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: rtl/isp_tracker.sv
module isp_tracker import isp_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int BLOCK_BITS = BLOCK_BITS_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF,
	localparam int LINE_W    = ADDR_W - BLOCK_BITS,
	localparam int PLB       = (PAGE_BITS > BLOCK_BITS) ? (PAGE_BITS - BLOCK_BITS) : 0,
	localparam int SW        = PLB + 5,
	localparam int JOB_W     = LINE_W + SW + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ADDR_W-1:0] access_addr,
	input  logic [ADDR_W-1:0] instr_ptr,
	input  logic [CAP_W-1:0]  mshr_occupancy,
	input  logic [CAP_W-1:0]  mshr_capacity,
	output logic              job_push,
	output logic [JOB_W-1:0]  job_data,
	input  logic              job_full
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int AGE_W = IDX_W;
	localparam int STR_W = LINE_W + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [STR_W-1:0] PAGE_LINES = STR_W'(64'd1 << PLB);

	typedef struct packed {
		logic [ADDR_W-1:0] key;
		logic [LINE_W-1:0] line;
		logic [STR_W-1:0]  stride;
		logic [AGE_W-1:0]  age;
	} entry_t;

	entry_t mem [ENTRIES];
	entry_t rdata_q;

	trk_state_t state_q, state_d;

	logic [IDX_W-1:0]  ptr_q;
	logic              rd_done_q;
	logic              chk_vld_q;
	logic [IDX_W-1:0]  chk_ptr_q;
	logic [LINE_W-1:0] cl_q;
	logic [ADDR_W-1:0] key_q;
	logic              llc_q;
	logic              found_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [LINE_W-1:0] hit_line_q;
	logic [STR_W-1:0]  hit_stride_q;
	logic [AGE_W-1:0]  hit_age_q;
	logic [IDX_W-1:0]  vic_idx_q;
	logic [AGE_W-1:0]  vic_age_q;
	logic [IDX_W-1:0]  tgt_q;
	logic [AGE_W-1:0]  mine_q;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              we;
	logic [IDX_W-1:0]  wa;
	entry_t            wd;

	logic [STR_W-1:0]  stride_now;
	logic              neg;
	logic [STR_W-1:0]  mag;
	logic              fire;
	logic              scan_end;
	logic              accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign scan_end = chk_vld_q && (chk_ptr_q == LAST_IDX);

	// Line stride of the access against the matching entry.
	assign stride_now = {1'b0, cl_q} - {1'b0, hit_line_q};
	assign neg        = stride_now[STR_W-1];
	assign mag        = neg ? (STR_W'(0) - stride_now) : stride_now;
	assign fire       = found_q && (stride_now != '0) && (stride_now == hit_stride_q) &&
	                    (mag < PAGE_LINES);

	assign job_data = {cl_q, SW'(mag), neg, llc_q};

	// Tracker memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (ptr_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (found_q && (stride_now == '0)) begin
					state_d = ST_IDLE;
				end else if (!(fire && job_full)) begin
					state_d = ST_TOUCH;
				end
			end
			ST_TOUCH: begin
				if (scan_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// Memory port and queue controls.
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = ptr_q;
		we       = 1'b0;
		wa       = ptr_q;
		wd       = '0;
		job_push = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				we     = 1'b1;
				wd.age = ptr_q;
			end
			ST_SCAN: begin
				rd_en = !rd_done_q;
			end
			ST_DECIDE: begin
				if (!(found_q && (stride_now == '0)) && !(fire && job_full)) begin
					we       = 1'b1;
					job_push = fire;
					wd.key   = key_q;
					wd.line  = cl_q;
					wd.age   = '0;
					if (found_q) begin
						wa        = hit_idx_q;
						wd.stride = stride_now;
					end else begin
						wa        = vic_idx_q;
						wd.stride = '0;
					end
				end
			end
			ST_TOUCH: begin
				rd_en = !rd_done_q;
				if (chk_vld_q && (chk_ptr_q != tgt_q) && (rdata_q.age < mine_q)) begin
					we     = 1'b1;
					wa     = chk_ptr_q;
					wd     = rdata_q;
					wd.age = rdata_q.age + AGE_W'(1);
				end
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			ptr_q     <= '0;
			rd_done_q <= 1'b0;
			chk_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			chk_vld_q <= ((state_q == ST_SCAN) || (state_q == ST_TOUCH)) && !rd_done_q;
			case (state_q)
				ST_CLEAR: begin
					ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + IDX_W'(1);
				end
				ST_IDLE: begin
					ptr_q     <= '0;
					rd_done_q <= 1'b0;
				end
				ST_SCAN, ST_TOUCH: begin
					if (!rd_done_q) begin
						if (ptr_q == LAST_IDX) begin
							rd_done_q <= 1'b1;
						end else begin
							ptr_q <= ptr_q + IDX_W'(1);
						end
					end
				end
				ST_DECIDE: begin
					ptr_q     <= '0;
					rd_done_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Item, search results and touch targets.
	always_ff @(posedge clk) begin
		chk_ptr_q <= ptr_q;
		if (accept) begin
			cl_q    <= access_addr[ADDR_W-1:BLOCK_BITS];
			key_q   <= instr_ptr;
			llc_q   <= (mshr_occupancy >= (mshr_capacity >> 1));
			found_q <= 1'b0;
		end
		if ((state_q == ST_SCAN) && chk_vld_q) begin
			if (!found_q && (rdata_q.key == key_q)) begin
				found_q      <= 1'b1;
				hit_idx_q    <= chk_ptr_q;
				hit_line_q   <= rdata_q.line;
				hit_stride_q <= rdata_q.stride;
				hit_age_q    <= rdata_q.age;
			end
			if ((chk_ptr_q == '0) || (rdata_q.age > vic_age_q)) begin
				vic_idx_q <= chk_ptr_q;
				vic_age_q <= rdata_q.age;
			end
		end
		if (state_q == ST_DECIDE) begin
			tgt_q  <= found_q ? hit_idx_q : vic_idx_q;
			mine_q <= found_q ? hit_age_q : vic_age_q;
		end
	end

endmodule

FILE: rtl/isp_issue.sv
module isp_issue import isp_pkg::*; #(
	parameter int DEGREE     = DEGREE_DEF,
	parameter int BLOCK_BITS = BLOCK_BITS_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF,
	localparam int LINE_W    = ADDR_W - BLOCK_BITS,
	localparam int PLB       = (PAGE_BITS > BLOCK_BITS) ? (PAGE_BITS - BLOCK_BITS) : 0,
	localparam int SW        = PLB + 5,
	localparam int JOB_W     = LINE_W + SW + 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [JOB_W-1:0]  job_data,
	input  logic              job_empty,
	output logic              job_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] prefetch_addr,
	output logic              to_llc,
	output logic              last_prefetch
);

	localparam int K_W = $clog2(DEGREE + 1);
	localparam logic [SW-1:0] PAGE_LINES = SW'(64'd1 << PLB);
	localparam logic [SW-1:0] PAGE_MASK  = SW'((64'd1 << PLB) - 64'd1);

	logic              busy_q;
	logic [LINE_W-1:0] cl_q;
	logic [SW-1:0]     mag_q;
	logic              neg_q;
	logic              llc_q;
	logic [SW-1:0]     step_q;
	logic [K_W-1:0]    k_q;
	logic              out_vld_q;
	logic [ADDR_W-1:0] addr_q;
	logic              llc_out_q;
	logic              last_q;

	logic [SW-1:0]     off;
	logic [SW-1:0]     step_nxt;
	logic              ok_cur;
	logic              ok_nxt;
	logic              adv;
	logic              is_last;
	logic [LINE_W-1:0] target;

	assign out_valid     = out_vld_q;
	assign prefetch_addr = addr_q;
	assign to_llc        = llc_out_q;
	assign last_prefetch = last_q;

	// Page checks for the current and the following target.
	assign off      = SW'(cl_q) & PAGE_MASK;
	assign step_nxt = step_q + mag_q;
	assign ok_cur   = neg_q ? (step_q <= off) : ((off + step_q) < PAGE_LINES);
	assign ok_nxt   = neg_q ? (step_nxt <= off) : ((off + step_nxt) < PAGE_LINES);
	assign is_last  = (k_q == K_W'(DEGREE)) || !ok_nxt;
	assign target   = neg_q ? (cl_q - LINE_W'(step_q)) : (cl_q + LINE_W'(step_q));

	assign adv     = !out_vld_q || out_ready;
	assign job_pop = !busy_q && !job_empty;

	// Walk through the targets of one job, one beat a cycle while out_ready does not hold the output back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (busy_q && adv && ok_cur) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			if (job_pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && adv && (!ok_cur || is_last)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Job and result payload.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			{cl_q, mag_q, neg_q, llc_q} <= job_data;
			step_q <= job_data[SW+1:2];
			k_q    <= K_W'(1);
		end else if (busy_q && adv && ok_cur) begin
			addr_q    <= {target, BLOCK_BITS'(0)};
			llc_out_q <= llc_q;
			last_q    <= is_last;
			step_q    <= step_nxt;
			k_q       <= k_q + K_W'(1);
		end
	end

endmodule

FILE: rtl/ip_stride_prefetcher.sv
// Channel | Direction | Beat contents
// in      | input     | access_addr, instr_ptr, mshr_occupancy
// out     | output    | prefetch_addr, to_llc, last_prefetch
// cfg     | input     | cfg_data (mshr_capacity)
//
// An access runs from one accepted beat to the next through one pass to search by key
// and find the LRU entry, a decision cycle, and one pass to age the entries, one entry
// a cycle each; a hit on an unchanged line skips the aging pass. After reset the
// tracker clears the whole table and takes no access until done. Prefetches use a
// two-job queue and leave at one beat a cycle while out_ready is high; the tracker
// waits in its decision cycle only while it holds a job and the queue is full.
module ip_stride_prefetcher import isp_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int DEGREE     = DEGREE_DEF,
	parameter int BLOCK_BITS = BLOCK_BITS_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CAP_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ADDR_W-1:0] access_addr,
	input  logic [ADDR_W-1:0] instr_ptr,
	input  logic [CAP_W-1:0]  mshr_occupancy,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] prefetch_addr,
	output logic              to_llc,
	output logic              last_prefetch
);

	localparam int LINE_W = ADDR_W - BLOCK_BITS;
	localparam int PLB    = (PAGE_BITS > BLOCK_BITS) ? (PAGE_BITS - BLOCK_BITS) : 0;
	localparam int SW     = PLB + 5;
	localparam int JOB_W  = LINE_W + SW + 2;

	logic [CAP_W-1:0] cap_q;
	logic             job_push;
	logic [JOB_W-1:0] job_in;
	logic             job_full;
	logic             job_pop;
	logic [JOB_W-1:0] job_out;
	logic             job_empty;

	// Capacity register.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	// Front: table search and update.
	isp_tracker #(
		.ENTRIES    (ENTRIES),
		.BLOCK_BITS (BLOCK_BITS),
		.PAGE_BITS  (PAGE_BITS)
	) u_tracker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.access_addr    (access_addr),
		.instr_ptr      (instr_ptr),
		.mshr_occupancy (mshr_occupancy),
		.mshr_capacity  (cap_q),
		.job_push       (job_push),
		.job_data       (job_in),
		.job_full       (job_full)
	);

	// Queue of prefetch jobs.
	isp_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.full      (job_full),
		.pop       (job_pop),
		.pop_data  (job_out),
		.empty     (job_empty)
	);

	// Back: prefetch address generation.
	isp_issue #(
		.DEGREE     (DEGREE),
		.BLOCK_BITS (BLOCK_BITS),
		.PAGE_BITS  (PAGE_BITS)
	) u_issue (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_data      (job_out),
		.job_empty     (job_empty),
		.job_pop       (job_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.prefetch_addr (prefetch_addr),
		.to_llc        (to_llc),
		.last_prefetch (last_prefetch)
	);

endmodule
